FILE: hw/rtl/stcm_pkg.sv
package stcm_pkg;

   localparam int SLOTS         = 8;
   localparam int TILE_BITS     = 8;
   localparam int TILES_PER_ROW = 16;
   localparam int IDLE_BITS     = 16;

   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int COORD_W     = 12;
   localparam int EXT_W       = COORD_W + 2;
   localparam int TILE_W      = 8;
   localparam int SIZE_W      = 9;
   localparam int OFS_W       = 8;
   localparam int OUT_SLOT_W  = 3;
   localparam int TILE_SIZE   = 1 << TILE_BITS;

   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [EXT_W-1:0]      ext_type;
   typedef logic [TILE_W-1:0]     tile_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [SIZE_W-1:0]     size_type;
   typedef logic [OFS_W-1:0]      ofs_type;
   typedef logic [OUT_SLOT_W-1:0] out_slot_type;
   typedef logic [IDLE_BITS-1:0]  idle_type;
   typedef logic [3:0][TILE_W-1:0] corner_set_type;

   localparam idle_type IDLE_MAX = '1;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_AGE,
      OP_SCAN,
      OP_LOAD
   } slot_op_type;

   typedef struct packed {
      slot_op_type op;
      slot_type    idx;
      tile_type    target;
   } slot_cmd_type;

   typedef struct packed {
      logic     found;
      slot_type found_slot;
      slot_type victim;
   } slot_res_type;

   typedef struct packed {
      logic     hit;
      size_type w;
      size_type h;
   } quad_type;

   function automatic tile_type tile_of(coord_type x, coord_type y);
      coord_type t;
      t = COORD_W'(x >> TILE_BITS) + COORD_W'((y >> TILE_BITS) * TILES_PER_ROW);
      return t[TILE_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/stcm_quad_geom.sv
module stcm_quad_geom (
   input  stcm_pkg::coord_type win_left,
   input  stcm_pkg::coord_type win_top,
   input  stcm_pkg::coord_type win_right,
   input  stcm_pkg::coord_type win_bottom,
   input  logic [1:0]          quad,
   output stcm_pkg::quad_type  geom
);
   import stcm_pkg::*;

   ext_type ql, qt, qr, qb;
   ext_type l, r, t, b;
   ext_type wl, wt, wr, wb;

   always_comb begin
      wl = EXT_W'(win_left);
      wt = EXT_W'(win_top);
      wr = EXT_W'(win_right);
      wb = EXT_W'(win_bottom);
      ql = (EXT_W'(win_left >> TILE_BITS) + EXT_W'(quad[0])) << TILE_BITS;
      qt = (EXT_W'(win_top >> TILE_BITS) + EXT_W'(quad[1])) << TILE_BITS;
      qr = ql + EXT_W'(TILE_SIZE);
      qb = qt + EXT_W'(TILE_SIZE);
      l  = (wl > ql) ? wl : ql;
      r  = (wr < qr) ? wr : qr;
      t  = (wt > qt) ? wt : qt;
      b  = (wb < qb) ? wb : qb;
      geom.hit = (l < r) && (t < b);
      if (geom.hit) begin
         geom.w = SIZE_W'(r - l);
         geom.h = SIZE_W'(b - t);
      end else begin
         geom.w = '0;
         geom.h = '0;
      end
   end

endmodule

FILE: hw/rtl/stcm_slot_table.sv
module stcm_slot_table (
   input  logic                     clock,
   input  logic                     reset,
   input  stcm_pkg::slot_cmd_type   cmd,
   input  stcm_pkg::corner_set_type corners,
   output stcm_pkg::slot_res_type   res
);
   import stcm_pkg::*;

   tile_type tile_ff [SLOTS];
   logic     valid_ff [SLOTS];
   idle_type idle_ff [SLOTS];

   logic     found_ff, found_in;
   slot_type found_slot_ff, found_slot_in;
   logic     empty_ff, empty_in;
   slot_type empty_slot_ff, empty_slot_in;
   idle_type most_ff, most_in;
   slot_type best_ff, best_in;

   tile_type cur_tile;
   logic     cur_valid;
   idle_type cur_idle;
   logic     used;
   slot_type victim;

   always_comb begin
      cur_tile  = tile_ff[cmd.idx];
      cur_valid = valid_ff[cmd.idx];
      cur_idle  = idle_ff[cmd.idx];
      used = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (cur_tile == corners[k]) used = 1'b1;
      end

      if (cmd.idx == '0) begin
         found_in      = 1'b0;
         found_slot_in = '0;
         empty_in      = 1'b0;
         empty_slot_in = '0;
         most_in       = '0;
         best_in       = '0;
      end else begin
         found_in      = found_ff;
         found_slot_in = found_slot_ff;
         empty_in      = empty_ff;
         empty_slot_in = empty_slot_ff;
         most_in       = most_ff;
         best_in       = best_ff;
      end
      if (cur_valid && (cur_tile == cmd.target) && !found_in) begin
         found_in      = 1'b1;
         found_slot_in = cmd.idx;
      end
      if (!cur_valid && !empty_in) begin
         empty_in      = 1'b1;
         empty_slot_in = cmd.idx;
      end
      if (cur_idle > most_in) begin
         most_in = cur_idle;
         best_in = cmd.idx;
      end

      victim         = empty_ff ? empty_slot_ff : best_ff;
      res.found      = found_ff;
      res.found_slot = found_slot_ff;
      res.victim     = victim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
            idle_ff[i]  <= '0;
         end
      end else begin
         case (cmd.op)
            OP_AGE: begin
               if (cur_valid && !used && (cur_idle < IDLE_MAX)) begin
                  idle_ff[cmd.idx] <= cur_idle + 1'b1;
               end
            end
            OP_LOAD: begin
               if (!found_ff) begin
                  valid_ff[victim] <= 1'b1;
                  idle_ff[victim]  <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_LOAD) && !found_ff) begin
         tile_ff[victim] <= cmd.target;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SCAN) begin
         found_ff      <= found_in;
         found_slot_ff <= found_slot_in;
         empty_ff      <= empty_in;
         empty_slot_ff <= empty_slot_in;
         most_ff       <= most_in;
         best_ff       <= best_in;
      end
   end

endmodule

FILE: hw/rtl/scroll_tile_cache_manager.sv
// Scroll tile cache manager.
// The req_ channel takes one scroll window (left, top, right, bottom in map
// pixels, right and bottom exclusive). For each window the rsp_ channel
// returns four transactions, one per corner in the order top-left,
// top-right, bottom-left, bottom-right; rsp_last marks the fourth. Each
// carries the corner tile, whether it was loaded and into which slot, the
// slot to copy from and the geometry of the quadrant copy.
// One slot compare unit walks the eight slots one per cycle: it first ages the
// idle counters, then for each corner searches the slots and loads the tile
// into a victim slot if it is missing, then for each corner looks up the copy
// slot. The first result is valid after the copy slot lookup for the first
// corner; each further one follows its own lookup once the previous is taken.
// req_ready is high only while no window is in progress.
// A stalled rsp_ready holds the current result and the whole sequencer.
// Reset empties all slots and clears the idle counters, with no clearing pass.
module scroll_tile_cache_manager (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  stcm_pkg::coord_type    req_win_left,
   input  stcm_pkg::coord_type    req_win_top,
   input  stcm_pkg::coord_type    req_win_right,
   input  stcm_pkg::coord_type    req_win_bottom,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stcm_pkg::tile_type     rsp_tile_number,
   output logic                   rsp_was_loaded,
   output stcm_pkg::out_slot_type rsp_load_slot,
   output logic                   rsp_copy_valid,
   output stcm_pkg::out_slot_type rsp_copy_slot,
   output stcm_pkg::size_type     rsp_dest_x,
   output stcm_pkg::size_type     rsp_dest_y,
   output stcm_pkg::size_type     rsp_size_x,
   output stcm_pkg::size_type     rsp_size_y,
   output stcm_pkg::ofs_type      rsp_src_x,
   output stcm_pkg::ofs_type      rsp_src_y,
   output logic                   rsp_last
);
   import stcm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_AGE  = 6'b000010,
      S_SCAN = 6'b000100,
      S_LOAD = 6'b001000,
      S_FIND = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type      state_ff, state_in;
   slot_type       idx_ff, idx_in;
   logic [1:0]     corner_ff, corner_in;
   coord_type      wl_ff, wl_in, wt_ff, wt_in, wr_ff, wr_in, wb_ff, wb_in;
   corner_set_type tiles_ff, tiles_in;
   logic [3:0]     loaded_ff, loaded_in;
   slot_type       lslot_ff [4];
   slot_type       lslot_in [4];

   slot_cmd_type cmd;
   slot_res_type res;
   quad_type     geom, geom0;
   logic         idx_last;
   logic         cv;

   stcm_slot_table u_slots (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .corners (tiles_ff),
      .res     (res)
   );

   stcm_quad_geom u_geom (
      .win_left   (wl_ff),
      .win_top    (wt_ff),
      .win_right  (wr_ff),
      .win_bottom (wb_ff),
      .quad       (corner_ff),
      .geom       (geom)
   );

   stcm_quad_geom u_geom0 (
      .win_left   (wl_ff),
      .win_top    (wt_ff),
      .win_right  (wr_ff),
      .win_bottom (wb_ff),
      .quad       (2'd0),
      .geom       (geom0)
   );

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      corner_in = corner_ff;
      wl_in     = wl_ff;
      wt_in     = wt_ff;
      wr_in     = wr_ff;
      wb_in     = wb_ff;
      tiles_in  = tiles_ff;
      loaded_in = loaded_ff;
      lslot_in  = lslot_ff;
      idx_last  = (idx_ff == SLOT_W'(SLOTS - 1));
      cmd.op     = OP_NONE;
      cmd.idx    = idx_ff;
      cmd.target = tiles_ff[corner_ff];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               wl_in       = req_win_left;
               wt_in       = req_win_top;
               wr_in       = req_win_right;
               wb_in       = req_win_bottom;
               tiles_in[0] = tile_of(req_win_left, req_win_top);
               tiles_in[1] = tile_of(req_win_right, req_win_top);
               tiles_in[2] = tile_of(req_win_left, req_win_bottom);
               tiles_in[3] = tile_of(req_win_right, req_win_bottom);
               idx_in      = '0;
               corner_in   = '0;
               state_in    = S_AGE;
            end
         end
         S_AGE: begin
            cmd.op = OP_AGE;
            idx_in = idx_last ? '0 : idx_ff + 1'b1;
            if (idx_last) state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            idx_in = idx_last ? '0 : idx_ff + 1'b1;
            if (idx_last) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.op               = OP_LOAD;
            loaded_in[corner_ff] = !res.found;
            lslot_in[corner_ff]  = res.found ? '0 : res.victim;
            idx_in               = '0;
            if (corner_ff == 2'd3) begin
               corner_in = '0;
               state_in  = S_FIND;
            end else begin
               corner_in = corner_ff + 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_FIND: begin
            cmd.op = OP_SCAN;
            idx_in = idx_last ? '0 : idx_ff + 1'b1;
            if (idx_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (corner_ff == 2'd3) begin
                  state_in = S_IDLE;
               end else begin
                  corner_in = corner_ff + 1'b1;
                  state_in  = S_FIND;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         idx_ff    <= '0;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         corner_ff <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      wl_ff     <= wl_in;
      wt_ff     <= wt_in;
      wr_ff     <= wr_in;
      wb_ff     <= wb_in;
      tiles_ff  <= tiles_in;
      loaded_ff <= loaded_in;
      lslot_ff  <= lslot_in;
   end

   always_comb begin
      cv              = geom.hit && res.found;
      req_ready       = (state_ff == S_IDLE);
      rsp_valid       = (state_ff == S_OUT);
      rsp_tile_number = tiles_ff[corner_ff];
      rsp_was_loaded  = loaded_ff[corner_ff];
      rsp_load_slot   = OUT_SLOT_W'(lslot_ff[corner_ff]);
      rsp_copy_valid  = cv;
      rsp_copy_slot   = cv ? OUT_SLOT_W'(res.found_slot) : '0;
      rsp_dest_x      = (cv && corner_ff[0]) ? geom0.w : '0;
      rsp_dest_y      = (cv && corner_ff[1]) ? geom0.h : '0;
      rsp_size_x      = cv ? geom.w : '0;
      rsp_size_y      = cv ? geom.h : '0;
      rsp_src_x       = (cv && !corner_ff[0]) ? OFS_W'(wl_ff & COORD_W'(TILE_SIZE - 1)) : '0;
      rsp_src_y       = (cv && !corner_ff[1]) ? OFS_W'(wt_ff & COORD_W'(TILE_SIZE - 1)) : '0;
      rsp_last        = (corner_ff == 2'd3);
   end

endmodule

FILE: hw/rtl/stcm_checker.sv
module stcm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input stcm_pkg::tile_type     rsp_tile_number,
   input logic                   rsp_was_loaded,
   input stcm_pkg::out_slot_type rsp_load_slot,
   input logic                   rsp_copy_valid,
   input stcm_pkg::out_slot_type rsp_copy_slot,
   input stcm_pkg::size_type     rsp_size_x,
   input stcm_pkg::size_type     rsp_size_y,
   input logic                   rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_number)
         && $stable(rsp_copy_slot) && $stable(rsp_last))
      else $error("stalled rsp transaction changed");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high while a rsp transaction is pending");

   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("window ended before its last rsp transaction");

   a_no_copy_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_copy_valid |-> rsp_copy_slot == '0 && rsp_size_x == '0
         && rsp_size_y == '0)
      else $error("copy fields set without copy_valid");

   a_no_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_loaded |-> rsp_load_slot == '0)
      else $error("load_slot set without was_loaded");

endmodule

bind scroll_tile_cache_manager stcm_checker u_stcm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_tile_number (rsp_tile_number),
   .rsp_was_loaded  (rsp_was_loaded),
   .rsp_load_slot   (rsp_load_slot),
   .rsp_copy_valid  (rsp_copy_valid),
   .rsp_copy_slot   (rsp_copy_slot),
   .rsp_size_x      (rsp_size_x),
   .rsp_size_y      (rsp_size_y),
   .rsp_last        (rsp_last)
);
